@@ rtl/fxalu_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Q24.8 fixed-point ALU: opcode type and pipeline sideband.
// No dependencies; imported by fixed_point_q24_8_alu.
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic cmp;
    logic dz;
    logic neg;
  } sb_t;

endpackage

@@ rtl/fxalu_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, then rounding.
// Depends on nothing outside itself; used by fixed_point_q24_8_alu.
module fxalu_div #(
  parameter int W = 32,
  parameter int F = 8
) (
  input  logic         clk,
  input  logic [W-1:0] num_mag,
  input  logic [W-1:0] den,
  input  logic         neg,
  output logic [W-1:0] quo
);

  localparam int DS = W + F;

  logic [W-1:0]  rem   [1:DS];
  logic [DS-1:0] nq    [1:DS];
  logic [W-1:0]  den_s [1:DS];
  logic          neg_s [1:DS];

  for (genvar k = 1; k <= DS; k++) begin : g_stage
    logic [W-1:0]  rem_p;
    logic [DS-1:0] nq_p;
    logic [W-1:0]  den_p;
    logic          neg_p;
    logic [W:0]    trial;
    logic          ge;
    logic [W:0]    diff;
    if (k == 1) begin : g_first
      assign rem_p = '0;
      assign nq_p  = {num_mag, {F{1'b0}}};
      assign den_p = den;
      assign neg_p = neg;
    end else begin : g_next
      assign rem_p = rem[k-1];
      assign nq_p  = nq[k-1];
      assign den_p = den_s[k-1];
      assign neg_p = neg_s[k-1];
    end
    assign trial = {rem_p, nq_p[DS-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};
    // shift in one quotient bit, keep the partial remainder
    always_ff @(posedge clk) begin
      rem[k]   <= ge ? diff[W-1:0] : trial[W-1:0];
      nq[k]    <= {nq_p[DS-2:0], ge};
      den_s[k] <= den_p;
      neg_s[k] <= neg_p;
    end
  end

  logic         up;
  logic [W-1:0] qr;
  // round half away from zero: bump when twice the remainder reaches the divisor
  assign up = {1'b0, rem[DS], 1'b0} >= {2'b00, den_s[DS]};
  assign qr = nq[DS][W-1:0] + {{(W-1){1'b0}}, up};

  always_ff @(posedge clk) begin
    quo <= neg_s[DS] ? (~qr + 1'b1) : qr;
  end

endmodule

@@ rtl/fixed_point_q24_8_alu.sv @@
`timescale 1ns / 1ps
// Top level of the Q24.8 fixed-point ALU: input stage, divider, multiplier, delay line, output.
// Depends on fxalu_pkg and fxalu_div.
//
// Fixed-point ALU for signed DATA_WIDTH-bit operands with FRAC_BITS fraction
// bits. An item (kind, a_raw, b_raw) is taken whenever start is high; busy is
// always low, so one item may enter on every clock. Every item comes out in
// order, with done high for one cycle alongside result_raw, compare_true and
// divide_by_zero. The receiver cannot stall: capture the result in the cycle
// done is high. The latency is set by the divider, which settles one quotient
// bit per pipeline stage; every other operation is delayed to match so all
// items share one fixed latency. Multiply and divide round half away from
// zero and wrap; add, subtract and the shifts wrap. A zero divisor gives
// result 0 with divide_by_zero set.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind,
  input  logic [31:0] a_raw,
  input  logic [31:0] b_raw,
  output logic        done,
  output logic [31:0] result_raw,
  output logic        compare_true,
  output logic        divide_by_zero
);
  import fxalu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DS = W + F;

  // never hold off the source: the pipeline advances every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  logic signed [W-1:0] a_s, b_s;
  logic [W-1:0]        res_c;
  logic                cmp_c;
  op_t                 op_c;

  assign a_s  = a_raw[W-1:0];
  assign b_s  = b_raw[W-1:0];
  assign op_c = op_t'(kind);

  // the simple operations finish here; mul and div are filled in later
  always_comb begin
    res_c = '0;
    cmp_c = 1'b0;
    case (op_c)
      OP_ADD:      res_c = a_s + b_s;
      OP_SUB:      res_c = a_s - b_s;
      OP_LT:       cmp_c = a_s < b_s;
      OP_GT:       cmp_c = a_s > b_s;
      OP_LE:       cmp_c = a_s <= b_s;
      OP_GE:       cmp_c = a_s >= b_s;
      OP_EQ:       cmp_c = a_s == b_s;
      OP_NE:       cmp_c = a_s != b_s;
      OP_MIN:      res_c = (a_s < b_s) ? a_s : b_s;
      OP_MAX:      res_c = (a_s > b_s) ? a_s : b_s;
      OP_INC:      res_c = a_s + 1'b1;
      OP_DEC:      res_c = a_s - 1'b1;
      OP_TO_INT:   res_c = a_s >>> F;
      OP_FROM_INT: res_c = a_s << F;
      default:     res_c = '0;
    endcase
  end

  sb_t          sb1;
  logic [W-1:0] res1;
  logic [W-1:0] mag_a1, mag_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb1.valid <= 1'b0;
    end else begin
      sb1.valid <= start & ~busy;
    end
    sb1.op  <= op_c;
    sb1.cmp <= cmp_c;
    sb1.dz  <= (op_c == OP_DIV) && (b_s == '0);
    sb1.neg <= a_s[W-1] ^ b_s[W-1];
    res1    <= res_c;
    // magnitudes fit in W unsigned bits, most negative value included
    mag_a1  <= a_s[W-1] ? (~a_s + 1'b1) : a_s;
    mag_b1  <= b_s[W-1] ? (~b_s + 1'b1) : b_s;
  end

  // ---------------------------------------------------------------- divider
  logic [W-1:0] div_q;

  fxalu_div #(
    .W (W),
    .F (F)
  ) u_div (
    .clk     (clk),
    .num_mag (mag_a1),
    .den     (mag_b1),
    .neg     (sb1.neg),
    .quo     (div_q)
  );

  // sb[j] and res_d[j] line up with the divider; the multiplier result joins at sb[1]
  sb_t          sb    [0:DS];
  logic [W-1:0] res_d [0:DS];

  // ---------------------------------------------------------------- multiplier
  logic [2*W-1:0] prod;
  logic [2*W-1:0] prod_rnd;
  logic [W-1:0]   mul_mag;
  logic [W-1:0]   mul_res;

  always_ff @(posedge clk) begin
    prod <= mag_a1 * mag_b1;
  end

  // add half an LSB of the result, drop the fraction, then restore the sign
  assign prod_rnd = prod + ({{(2*W-1){1'b0}}, 1'b1} << (F-1));
  assign mul_mag  = prod_rnd[F+W-1:F];
  assign mul_res  = sb[0].neg ? (~mul_mag + 1'b1) : mul_mag;

  // ---------------------------------------------------------------- delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      sb[0].valid <= 1'b0;
    end else begin
      sb[0].valid <= sb1.valid;
    end
    sb[0].op  <= sb1.op;
    sb[0].cmp <= sb1.cmp;
    sb[0].dz  <= sb1.dz;
    sb[0].neg <= sb1.neg;
    res_d[0]  <= res1;
  end

  for (genvar j = 1; j <= DS; j++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        sb[j].valid <= 1'b0;
      end else begin
        sb[j].valid <= sb[j-1].valid;
      end
      sb[j].op  <= sb[j-1].op;
      sb[j].cmp <= sb[j-1].cmp;
      sb[j].dz  <= sb[j-1].dz;
      sb[j].neg <= sb[j-1].neg;
      if (j == 1) begin
        res_d[j] <= (sb[j-1].op == OP_MUL) ? mul_res : res_d[j-1];
      end else begin
        res_d[j] <= res_d[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [W-1:0] res_out;

  always_comb begin
    res_out = res_d[DS];
    if (sb[DS].op == OP_DIV) begin
      res_out = sb[DS].dz ? '0 : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sb[DS].valid;
    end
    // sign-extend the DATA_WIDTH result onto the 32-bit port
    result_raw     <= 32'(signed'(res_out));
    compare_true   <= sb[DS].cmp;
    divide_by_zero <= sb[DS].dz;
  end

endmodule
